@@ rtl/core/ddpi_pkg.sv @@
// Shared types, register codes and the arctangent table for the
// differential-drive pose integrator. No dependencies.
package ddpi_pkg;

    // payload types
    typedef logic signed [15:0] t_speed;
    typedef logic signed [31:0] t_pos;
    typedef logic [15:0] t_heading_hi;
    typedef logic [1:0] t_cfg_index;
    typedef logic [15:0] t_cfg_data;

    // configuration register indexes
    localparam t_cfg_index CFG_MAX_SPEED = 2'd0;
    localparam t_cfg_index CFG_STEP_TIME = 2'd1;
    localparam t_cfg_index CFG_TURN_GAIN = 2'd2;

    // configuration reset values
    localparam logic [14:0] MAX_SPEED_RST = 15'd17203;
    localparam logic [15:0] STEP_TIME_RST = 16'd328;
    localparam logic [15:0] TURN_GAIN_RST = 16'd4346;

    // input action codes
    localparam logic ACT_ACCEL = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // cordic gain compensation, Q.28
    localparam logic signed [31:0] CORDIC_K_Q28 = 32'sd163008219;

    // arctangent of 2^-i in heading units (full turn is 2^32)
    localparam int ANGLE_TABLE_LEN = 24;
    localparam int ANGLE_IDX_W     = 5;
    localparam logic [31:0] ATAN_TURNS [0:ANGLE_TABLE_LEN-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // limit a 17-bit speed sum to plus or minus the limit
    function automatic t_speed clamp_speed(input logic signed [16:0] sum,
                                           input logic [14:0] lim);
        logic signed [16:0] pos_lim;
        logic signed [16:0] neg_lim;
        logic signed [16:0] res;
        pos_lim = {2'b00, lim};
        neg_lim = -pos_lim;
        if (sum > pos_lim) begin
            res = pos_lim;
        end else if (sum < neg_lim) begin
            res = neg_lim;
        end else begin
            res = sum;
        end
        return res[15:0];
    endfunction

endpackage

@@ rtl/core/diff_drive_pose_integrator_top.sv @@
// Differential-drive pose integrator: wheel speeds, heading and x/y position.
// Depends on ddpi_pkg (types, register codes, arctangent table).
//
// Usage
//   Input channel (i_in_valid / o_in_stall) takes one beat per item: an
//   accelerate item adds the two increments to the wheel speeds and clamps
//   them, a tick item turns the heading and moves the position.
//   Output channel (o_out_valid / i_out_stall) gives one beat per item with
//   the state after that item.
//   Config channel (i_cfg_valid / o_cfg_ready) writes max_speed, step_time
//   and turn_gain and is always ready; the user is to write it only while
//   idle, which the block itself does not enforce.
// Sequence
//   Accelerate: the speeds are registered on the beat and the final state
//   then loads the output. Tick: turn-gain, heading and path multiplies,
//   CORDIC_STEPS cordic iterations, one quadrant swap and the x and y high
//   and low partial products on the one shared 33x17 multiplier, then the
//   final state. A new item is taken only in idle, after the final state.
// Reset clears the pose, the speeds and the output valid, and loads the
// register defaults. While the receiver stalls, the finished result is held
// in the output register; a next item may be taken meanwhile but its result
// waits in the final state until the output register is free.
module diff_drive_pose_integrator_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_action,
    input  ddpi_pkg::t_speed      i_left_accel,
    input  ddpi_pkg::t_speed      i_right_accel,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ddpi_pkg::t_pos        o_pos_x_out,
    output ddpi_pkg::t_pos        o_pos_y_out,
    output ddpi_pkg::t_heading_hi o_heading_out,
    output ddpi_pkg::t_speed      o_left_speed_out,
    output ddpi_pkg::t_speed      o_right_speed_out,
    // configuration channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  ddpi_pkg::t_cfg_index  i_cfg_index,
    input  ddpi_pkg::t_cfg_data   i_cfg_data
);
    import ddpi_pkg::*;

    // sequencer codes
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL_TG = 4'd1;
    localparam logic [3:0] S_MUL_DH = 4'd2;
    localparam logic [3:0] S_MUL_P  = 4'd3;
    localparam logic [3:0] S_CORDIC = 4'd4;
    localparam logic [3:0] S_ROT    = 4'd5;
    localparam logic [3:0] S_XH     = 4'd6;
    localparam logic [3:0] S_XL     = 4'd7;
    localparam logic [3:0] S_YH     = 4'd8;
    localparam logic [3:0] S_YL     = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;

    localparam logic [ANGLE_IDX_W-1:0] LAST_STEP = ANGLE_IDX_W'(CORDIC_STEPS - 1);
    localparam logic [63:0] ROUND_41 = 64'h0000_0100_0000_0000;

    // control state
    logic [3:0] r_state, n_state;
    logic       r_out_valid;

    // configuration
    logic [14:0] r_max_speed;
    logic [15:0] r_step_time;
    logic [15:0] r_turn_gain;

    // architectural state
    t_speed      r_left_speed, r_right_speed;
    logic [31:0] r_heading;
    logic [31:0] r_pos_x, r_pos_y;

    // datapath registers
    logic [31:0]              r_m;
    logic signed [32:0]       r_p;
    logic signed [63:0]       r_acc;
    logic signed [31:0]       r_cx, r_cy, r_cz;
    logic [1:0]               r_quad;
    logic [ANGLE_IDX_W-1:0]   r_count;
    logic signed [31:0]       r_c, r_s;

    // output registers
    t_pos        r_out_pos_x, r_out_pos_y;
    t_heading_hi r_out_heading;
    t_speed      r_out_left, r_out_right;

    // handshake
    logic in_acc, out_take, out_load;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;
    assign out_load    = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);
    assign o_cfg_ready = 1'b1;

    // accelerate path
    logic signed [16:0] l_sum, r_sum;
    t_speed             l_new, r_new;
    assign l_sum = {r_left_speed[15], r_left_speed} + {i_left_accel[15], i_left_accel};
    assign r_sum = {r_right_speed[15], r_right_speed} + {i_right_accel[15], i_right_accel};
    assign l_new = clamp_speed(l_sum, r_max_speed);
    assign r_new = clamp_speed(r_sum, r_max_speed);

    // wheel difference and sum
    logic signed [16:0] spd_diff, spd_sum;
    assign spd_diff = {r_right_speed[15], r_right_speed} - {r_left_speed[15], r_left_speed};
    assign spd_sum  = {r_right_speed[15], r_right_speed} + {r_left_speed[15], r_left_speed};

    // shared multiplier and its operand select
    logic signed [31:0] trig;
    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [49:0] mul_prod;
    assign trig = ((r_state == S_XH) || (r_state == S_XL)) ? r_c : r_s;

    always_comb begin
        mul_a = {17'd0, r_step_time};
        mul_b = {1'b0, r_turn_gain};
        unique case (r_state)
            S_MUL_DH: begin
                mul_a = {1'b0, r_m};
                mul_b = spd_diff;
            end
            S_MUL_P: begin
                mul_b = spd_sum;
            end
            S_XH, S_YH: begin
                mul_a = r_p;
                mul_b = {trig[31], trig[31:16]};
            end
            S_XL, S_YL: begin
                mul_a = r_p;
                mul_b = {1'b0, trig[15:0]};
            end
            default: begin
                mul_a = {17'd0, r_step_time};
                mul_b = {1'b0, r_turn_gain};
            end
        endcase
    end

    assign mul_prod = mul_a * mul_b;

    // heading increment, rounded half up
    logic [39:0] dth_sum;
    assign dth_sum = mul_prod[39:0] + 40'd128;

    // position increment: high partial product plus low, rounded
    logic signed [63:0] prod_ext, pos_sum;
    logic [31:0]        dpos;
    assign prod_ext = {{14{mul_prod[49]}}, mul_prod};
    assign pos_sum  = r_acc + prod_ext + ROUND_41;
    assign dpos     = {{9{pos_sum[63]}}, pos_sum[63:41]};

    // cordic fold of the new heading
    logic [31:0] ang_off, ang_red;
    logic [1:0]  quad;
    assign ang_off = r_heading + 32'h2000_0000;
    assign quad    = ang_off[31:30];
    assign ang_red = r_heading - {quad, 30'd0};

    // cordic step
    logic signed [31:0] xs, ys, atan_i;
    assign xs     = r_cx >>> r_count;
    assign ys     = r_cy >>> r_count;
    assign atan_i = ATAN_TURNS[r_count];

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_action == ACT_TICK) ? S_MUL_TG : S_FIN;
                end
            end
            S_MUL_TG: n_state = S_MUL_DH;
            S_MUL_DH: n_state = S_MUL_P;
            S_MUL_P:  n_state = S_CORDIC;
            S_CORDIC: begin
                if (r_count == LAST_STEP) begin
                    n_state = S_ROT;
                end
            end
            S_ROT:    n_state = S_XH;
            S_XH:     n_state = S_XL;
            S_XL:     n_state = S_YH;
            S_YH:     n_state = S_YL;
            S_YL:     n_state = S_FIN;
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // control, configuration and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_max_speed   <= MAX_SPEED_RST;
            r_step_time   <= STEP_TIME_RST;
            r_turn_gain   <= TURN_GAIN_RST;
            r_left_speed  <= '0;
            r_right_speed <= '0;
            r_heading     <= '0;
            r_pos_x       <= '0;
            r_pos_y       <= '0;
        end else begin
            r_state <= n_state;

            // output valid
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end

            // register writes
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_MAX_SPEED: r_max_speed <= i_cfg_data[14:0];
                    CFG_STEP_TIME: r_step_time <= i_cfg_data;
                    CFG_TURN_GAIN: r_turn_gain <= i_cfg_data;
                    default: ;
                endcase
            end

            // accelerate
            if (in_acc && (i_action == ACT_ACCEL)) begin
                r_left_speed  <= l_new;
                r_right_speed <= r_new;
            end

            // heading and position updates
            if (r_state == S_MUL_DH) begin
                r_heading <= r_heading + dth_sum[39:8];
            end
            if (r_state == S_XL) begin
                r_pos_x <= r_pos_x + dpos;
            end
            if (r_state == S_YL) begin
                r_pos_y <= r_pos_y + dpos;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_MUL_TG: r_m <= mul_prod[31:0];
            S_MUL_P: begin
                r_p     <= mul_prod[32:0];
                r_cx    <= CORDIC_K_Q28;
                r_cy    <= '0;
                r_cz    <= signed'(ang_red);
                r_quad  <= quad;
                r_count <= '0;
            end
            S_CORDIC: begin
                if (!r_cz[31]) begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_cz <= r_cz - atan_i;
                end else begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_cz <= r_cz + atan_i;
                end
                r_count <= r_count + 1'b1;
            end
            S_ROT: begin
                case (r_quad)
                    2'd0: begin
                        r_c <= r_cx;
                        r_s <= r_cy;
                    end
                    2'd1: begin
                        r_c <= -r_cy;
                        r_s <= r_cx;
                    end
                    2'd2: begin
                        r_c <= -r_cx;
                        r_s <= -r_cy;
                    end
                    default: begin
                        r_c <= r_cy;
                        r_s <= -r_cx;
                    end
                endcase
            end
            S_XH, S_YH: r_acc <= prod_ext <<< 16;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_pos_x   <= r_pos_x;
            r_out_pos_y   <= r_pos_y;
            r_out_heading <= r_heading[31:16];
            r_out_left    <= r_left_speed;
            r_out_right   <= r_right_speed;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_pos_x_out       = r_out_pos_x;
    assign o_pos_y_out       = r_out_pos_y;
    assign o_heading_out     = r_out_heading;
    assign o_left_speed_out  = r_out_left;
    assign o_right_speed_out = r_out_right;

    // checks
    a_tick_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_action == ACT_TICK)) |=> (r_state == S_MUL_TG))
        else $error("tick beat did not start the multiply sequence");

    a_accel_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_action == ACT_ACCEL)) |=> (r_state == S_FIN))
        else $error("accelerate beat did not go to the final state");

    a_cordic_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CORDIC) |-> (r_count <= LAST_STEP))
        else $error("cordic iteration count ran past the step count");

    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("output valid rose outside the final state");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(r_out_pos_x) && $stable(r_out_heading))
        else $error("held result was overwritten");

endmodule
